// ===== design/dqqp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqqp_pkg
// Shared types and constants of the DNS query question parser.
// ----------------------------------------------------------------------------
package dqqp_pkg;

   // Header layout: offsets of the last byte of each checked field
   localparam int HDR_ID_END    = 1;
   localparam int HDR_FLAGS_END = 3;
   localparam int HDR_QD_END    = 5;
   localparam int HDR_LAST      = 11;
   localparam int MIN_MSG_BYTES = HDR_LAST + 1 + 5;
   // Span from the name terminator to just past QCLASS
   localparam int TC_SPAN       = 5;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   localparam int QEND_W = 13;

   // Verdict status codes
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_TOO_SHORT    = 4'd1;
   localparam logic [3:0] ST_IS_RESPONSE  = 4'd2;
   localparam logic [3:0] ST_BAD_OPCODE   = 4'd3;
   localparam logic [3:0] ST_QDCOUNT      = 4'd4;
   localparam logic [3:0] ST_POINTER      = 4'd5;
   localparam logic [3:0] ST_TOO_MANY     = 4'd6;
   localparam logic [3:0] ST_TRUNCATED    = 4'd7;
   localparam logic [3:0] ST_ROOT         = 4'd8;
   localparam logic [3:0] ST_NO_TYPECLASS = 4'd9;

   // Result queue depth (power of two, at least 4)
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic              kind;
      logic [7:0]        name_char;
      logic              is_last;
      logic              accepted;
      logic [3:0]        status;
      logic [15:0]       message_id;
      logic              recursion_desired;
      logic [15:0]       query_type;
      logic [15:0]       query_class;
      logic [QEND_W-1:0] question_end;
   } result_type;

   // Up to two results from one byte, in output order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic upper_ascii;
      logic upper_latin;
      upper_ascii = (b >= 8'h41) && (b <= 8'h5A);
      upper_latin = (b >= 8'hC0) && (b <= 8'hDE) && (b != 8'hD7);
      fold_case   = (upper_ascii || upper_latin) ? (b + 8'h20) : b;
   endfunction

endpackage
`default_nettype wire

// ===== design/dqqp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqqp_parse
// Running parse state; turns one message byte into name output and verdict.
// ----------------------------------------------------------------------------
module dqqp_parse
   import dqqp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 4096,
   parameter int MAX_LABELS        = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       go,
   input  wire logic [7:0] byte_value,
   input  wire logic       end_of_message,
   output push_type        push
);

   localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int EO_W  = $clog2(MAX_MESSAGE_BYTES + TC_SPAN);
   localparam int LC_W  = $clog2(MAX_LABELS + 1);

   localparam logic [2:0] PH_HEADER    = 3'd0;
   localparam logic [2:0] PH_LENGTH    = 3'd1;
   localparam logic [2:0] PH_LABEL     = 3'd2;
   localparam logic [2:0] PH_TYPECLASS = 3'd3;
   localparam logic [2:0] PH_DONE      = 3'd4;
   localparam logic [2:0] PH_FAILED    = 3'd5;

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [2:0]       phase_ff, phase_in;
   logic [15:0]      hw_ff,    hw_in;
   logic [15:0]      id_ff,    id_in;
   logic [15:0]      flags_ff, flags_in;
   logic [5:0]       left_ff,  left_in;
   logic [LC_W-1:0]  lc_ff,    lc_in;
   logic [3:0]       err_ff,   err_in;
   logic [31:0]      tc_ff,    tc_in;
   logic [EO_W-1:0]  eo_ff,    eo_in;

   logic             active;
   logic [LC_W:0]    lc_inc;
   logic             char_valid;
   logic [7:0]       char_value;
   logic [3:0]       status;
   result_type       char_res;
   result_type       verdict;

   always_comb begin
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      hw_in      = hw_ff;
      id_in      = id_ff;
      flags_in   = flags_ff;
      left_in    = left_ff;
      lc_in      = lc_ff;
      err_in     = err_ff;
      tc_in      = tc_ff;
      eo_in      = eo_ff;
      char_valid = 1'b0;
      char_value = DOT_CHAR;
      lc_inc     = {1'b0, lc_ff} + (LC_W + 1)'(1);
      active     = pos_ff < POS_W'(MAX_MESSAGE_BYTES);

      if (active) begin
         pos_in = pos_ff + POS_W'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               hw_in = {hw_ff[7:0], byte_value};
               if (pos_ff == POS_W'(HDR_ID_END)) begin
                  id_in = hw_in;
               end else if (pos_ff == POS_W'(HDR_FLAGS_END)) begin
                  flags_in = hw_in;
                  if (hw_in[15]) begin
                     err_in   = ST_IS_RESPONSE;
                     phase_in = PH_FAILED;
                  end else if (hw_in[14:11] != 4'd0) begin
                     err_in   = ST_BAD_OPCODE;
                     phase_in = PH_FAILED;
                  end
               end else if (pos_ff == POS_W'(HDR_QD_END)) begin
                  if (hw_in != 16'd1) begin
                     err_in   = ST_QDCOUNT;
                     phase_in = PH_FAILED;
                  end
               end
               if (phase_in == PH_HEADER && pos_ff == POS_W'(HDR_LAST)) begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (byte_value == 8'd0) begin
                  if (lc_ff == '0) begin
                     err_in   = ST_ROOT;
                     phase_in = PH_FAILED;
                  end else begin
                     phase_in = PH_TYPECLASS;
                     eo_in    = EO_W'(pos_ff) + EO_W'(TC_SPAN);
                  end
               end else if (byte_value[7:6] != 2'b00) begin
                  err_in   = ST_POINTER;
                  phase_in = PH_FAILED;
               end else begin
                  lc_in = LC_W'(lc_inc);
                  if (lc_inc > (LC_W + 1)'(MAX_LABELS)) begin
                     err_in   = ST_TOO_MANY;
                     phase_in = PH_FAILED;
                  end else begin
                     // separator before every label but the first
                     char_valid = (lc_ff != '0);
                     char_value = DOT_CHAR;
                     left_in    = byte_value[5:0];
                     phase_in   = PH_LABEL;
                  end
               end
            end
            PH_LABEL: begin
               char_valid = 1'b1;
               char_value = fold_case(byte_value);
               left_in    = left_ff - 6'd1;
               if (left_in == 6'd0) begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_TYPECLASS: begin
               tc_in = {tc_ff[23:0], byte_value};
               if (EO_W'(pos_ff) + EO_W'(1) == eo_ff) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Verdict from the state after this byte
   always_comb begin
      if (pos_in < POS_W'(MIN_MSG_BYTES)) begin
         status = ST_TOO_SHORT;
      end else if (err_in != 4'd0) begin
         status = err_in;
      end else if (phase_in == PH_DONE) begin
         status = ST_OK;
      end else if (phase_in == PH_LABEL) begin
         status = ST_TRUNCATED;
      end else if (phase_in == PH_LENGTH && lc_in == '0) begin
         status = ST_ROOT;
      end else begin
         status = ST_NO_TYPECLASS;
      end

      verdict           = '0;
      verdict.kind      = 1'b1;
      verdict.is_last   = 1'b1;
      verdict.status    = status;
      if (status == ST_OK) begin
         verdict.accepted          = 1'b1;
         verdict.message_id        = id_in;
         verdict.recursion_desired = flags_in[8];
         verdict.query_type        = tc_in[31:16];
         verdict.query_class       = tc_in[15:0];
         verdict.question_end      = QEND_W'(eo_in);
      end

      char_res           = '0;
      char_res.name_char = char_value;

      push = '0;
      if (go) begin
         if (char_valid && end_of_message) begin
            push.count  = 2'd2;
            push.first  = char_res;
            push.second = verdict;
         end else if (char_valid) begin
            push.count = 2'd1;
            push.first = char_res;
         end else if (end_of_message) begin
            push.count = 2'd1;
            push.first = verdict;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (go && end_of_message)) begin
         pos_ff   <= '0;
         phase_ff <= PH_HEADER;
         hw_ff    <= '0;
         id_ff    <= '0;
         flags_ff <= '0;
         left_ff  <= '0;
         lc_ff    <= '0;
         err_ff   <= '0;
         tc_ff    <= '0;
         eo_ff    <= '0;
      end else if (go) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         hw_ff    <= hw_in;
         id_ff    <= id_in;
         flags_ff <= flags_in;
         left_ff  <= left_in;
         lc_ff    <= lc_in;
         err_ff   <= err_in;
         tc_ff    <= tc_in;
         eo_ff    <= eo_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/dqqp_rsp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqqp_rsp_queue
// Small result queue: takes up to two results a cycle, gives one when out_ready.
// ----------------------------------------------------------------------------
module dqqp_rsp_queue
   import dqqp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire push_type  push,
   output logic           room,
   output logic           out_valid,
   input  wire logic      out_ready,
   output result_type     out_data
);

   result_type           slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] head_ff, head_in;
   logic [RSP_PTR_W-1:0] tail_ff, tail_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   logic [RSP_PTR_W-1:0] tail_next;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[head_ff];
   assign pop       = out_valid && out_ready;
   // room for the worst case of two results
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign tail_next = tail_ff + RSP_PTR_W'(1);

   always_comb begin
      head_in  = pop ? head_ff + RSP_PTR_W'(1) : head_ff;
      tail_in  = tail_ff + RSP_PTR_W'(push.count);
      count_in = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[tail_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/dns_query_question_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_query_question_parser_unit
// Streaming DNS query checker and question-name extractor.
// ----------------------------------------------------------------------------
// Feed a DNS message one byte per request, with req_tlast on its final byte.
// The unit checks the 12-byte header (QR clear, OPCODE zero, QDCOUNT one),
// walks the question name and returns each name byte lowercased (A-Z and
// Latin-1 0xC0-0xDE except 0xD7), with a dot between labels, as a result with
// rsp_tuser low. The final byte yields one verdict result (rsp_tuser and
// rsp_tlast high) carrying status, ID, RD, QTYPE, QCLASS and the offset just
// past QCLASS; those header fields read zero unless the status is ok, and
// name bytes already returned are only meaningful when it is. A message under
// 17 bytes always reports too_short; otherwise the first fault in byte order
// wins. Bytes past the question, and past MAX_MESSAGE_BYTES, are ignored.
// Throughput is one byte per cycle: each byte is taken into an input register
// and processed by the parse stage; results go into a four-entry queue, and
// the input stalls only when that queue cannot take two results (a name
// byte that also ends the message gives two, which then drain one per cycle
// while rsp_tready is high).
// ----------------------------------------------------------------------------
module dns_query_question_parser_unit
   import dqqp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 4096,
   parameter int MAX_LABELS        = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tlast,   // end_of_message
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [7:0] name_char, [8] accepted,
                                         // [12:9] status, [28:13] message_id,
                                         // [29] recursion_desired,
                                         // [45:30] query_type,
                                         // [61:46] query_class,
                                         // [74:62] question_end, rest zero
   output logic             rsp_tlast,   // is_last
   output logic [0:0]       rsp_tuser    // [0] kind
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic       room;
   logic       stage_go;
   logic       req_take;
   push_type   push;
   result_type head;

   // Advance the held byte only when the queue can absorb its results
   assign stage_go   = in_valid_ff && room;
   assign req_tready = !in_valid_ff || stage_go;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold payload until the stage takes it
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   dqqp_parse #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
      .MAX_LABELS        (MAX_LABELS)
   ) u_parse (
      .clock          (clock),
      .reset          (reset),
      .go             (stage_go),
      .byte_value     (in_byte_ff),
      .end_of_message (in_last_ff),
      .push           (push)
   );

   dqqp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   // Pack the head result onto the bus
   assign rsp_tdata = {5'd0,
                       head.question_end,
                       head.query_class,
                       head.query_type,
                       head.recursion_desired,
                       head.message_id,
                       head.status,
                       head.accepted,
                       head.name_char};
   assign rsp_tlast = head.is_last;
   assign rsp_tuser = head.kind;

endmodule
`default_nettype wire
